// ===== sv/cau_pkg.sv =====
package cau_pkg;

   localparam int FUNC_W = 4;

   localparam logic [FUNC_W-1:0] FUNC_ADD = 4'd0;
   localparam logic [FUNC_W-1:0] FUNC_SUB = 4'd1;
   localparam logic [FUNC_W-1:0] FUNC_MUL = 4'd2;
   localparam logic [FUNC_W-1:0] FUNC_DIV = 4'd3;
   localparam logic [FUNC_W-1:0] FUNC_EQ  = 4'd4;
   localparam logic [FUNC_W-1:0] FUNC_NE  = 4'd5;
   localparam logic [FUNC_W-1:0] FUNC_LT  = 4'd6;
   localparam logic [FUNC_W-1:0] FUNC_GT  = 4'd7;
   localparam logic [FUNC_W-1:0] FUNC_LE  = 4'd8;
   localparam logic [FUNC_W-1:0] FUNC_GE  = 4'd9;

endpackage

// ===== sv/complex_arithmetic_unit_core.sv =====
// Registers from req beat to rsp_valid: s1_ff, s2_ff, dv_ff[0] to dv_ff[QB], then the rsp registers.
// Throughput: one beat per cycle while the rsp side does not stall; the divide is a restoring divider unrolled
// one quotient bit per stage (COMPONENT_WIDTH + 1 stages), so nothing iterates.
// A stalled rsp side fills bubbles first; req_ready drops only when all stages hold.
// Reset (synchronous, active high) clears every valid bit; payload is not reset.
module complex_arithmetic_unit_core #(
   parameter int COMPONENT_WIDTH = 16,
   parameter int FRACTION_BITS   = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [cau_pkg::FUNC_W-1:0]           req_func,
   input  logic signed [COMPONENT_WIDTH-1:0]    req_a_real,
   input  logic signed [COMPONENT_WIDTH-1:0]    req_a_imag,
   input  logic signed [COMPONENT_WIDTH-1:0]    req_b_real,
   input  logic signed [COMPONENT_WIDTH-1:0]    req_b_imag,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [COMPONENT_WIDTH-1:0]    rsp_res_real,
   output logic signed [COMPONENT_WIDTH-1:0]    rsp_res_imag,
   output logic                                 rsp_compare_true,
   output logic                                 rsp_overflow,
   output logic                                 rsp_divide_by_zero
);
   import cau_pkg::*;

   localparam int W   = COMPONENT_WIDTH;
   localparam int F   = FRACTION_BITS;
   localparam int PW  = 2 * W;
   localparam int SW  = 2 * W + 1;
   localparam int QB  = W + 1;
   localparam int NNW = 2 * W + F;
   localparam int CW  = NNW + QB;

   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic                 eq;
      logic signed [W:0]    sum_re;
      logic signed [W:0]    sum_im;
      logic signed [PW-1:0] p_rr;
      logic signed [PW-1:0] p_ii;
      logic signed [PW-1:0] p_ri;
      logic signed [PW-1:0] p_ir;
      logic [PW-1:0]        sq_ar;
      logic [PW-1:0]        sq_ai;
      logic [PW-1:0]        sq_br;
      logic [PW-1:0]        sq_bi;
   } prod_stage_type;

   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic                 eq;
      logic signed [W:0]    sum_re;
      logic signed [W:0]    sum_im;
      logic signed [SW-1:0] mul_re;
      logic signed [SW-1:0] mul_im;
      logic signed [SW-1:0] div_re;
      logic signed [SW-1:0] div_im;
      logic [PW-1:0]        mod_a;
      logic [PW-1:0]        mod_b;
   } sum_stage_type;

   typedef struct packed {
      logic           is_div;
      logic           neg_re;
      logic           neg_im;
      logic           cmp;
      logic           dz;
      logic           big_re;
      logic           big_im;
      logic [SW-1:0]  mag_re;
      logic [SW-1:0]  mag_im;
      logic [NNW-1:0] rem_re;
      logic [NNW-1:0] rem_im;
      logic [QB-1:0]  q_re;
      logic [QB-1:0]  q_im;
      logic [PW-1:0]  den;
   } div_stage_type;

   function automatic logic [SW-1:0] abs_sw(input logic signed [SW-1:0] v);
      return v[SW-1] ? SW'(-v) : SW'(v);
   endfunction

   function automatic logic [W:0] sat(input logic neg, input logic [SW-1:0] mag);
      logic [SW-1:0] lim;
      logic [SW-1:0] negm;
      lim  = SW'(1) << (W - 1);
      negm = SW'(-mag);
      if (neg) begin
         if (mag > lim) begin
            return {1'b1, 1'b1, {(W-1){1'b0}}};
         end
         return {1'b0, negm[W-1:0]};
      end
      if (mag > lim - SW'(1)) begin
         return {1'b1, 1'b0, {(W-1){1'b1}}};
      end
      return {1'b0, mag[W-1:0]};
   endfunction

   prod_stage_type s1_ff, s1_in;
   sum_stage_type  s2_ff, s2_in;
   div_stage_type  dv_ff [QB+1];
   div_stage_type  dv_in [QB+1];
   div_stage_type  dv0_in;
   logic           v1_ff, v2_ff;
   logic [QB:0]    dvv_ff;
   logic           ld1, ld2, ld_out;
   logic [QB:0]    ld_dv;

   logic [CW-1:0]  trial   [QB];
   logic [CW-1:0]  rx_re   [QB];
   logic [CW-1:0]  rx_im   [QB];
   logic [SW-1:0]  abs_dre, abs_dim, abs_mre, abs_mim;
   logic [NNW-1:0] num_re, num_im;
   logic [CW-1:0]  den_top;

   logic [SW-1:0]  fin_mag_re, fin_mag_im;
   logic [W:0]     fin_re, fin_im;

   logic signed [W-1:0] rsp_res_real_ff, rsp_res_imag_ff;
   logic           rsp_valid_ff, rsp_cmp_ff, rsp_ovf_ff, rsp_dz_ff;

   // stage readiness, back from the rsp side
   always_comb begin
      ld_out    = !rsp_valid_ff || rsp_ready;
      ld_dv[QB] = !dvv_ff[QB] || ld_out;
      for (int k = QB - 1; k >= 0; k--) begin
         ld_dv[k] = !dvv_ff[k] || ld_dv[k+1];
      end
      ld2 = !v2_ff || ld_dv[0];
      ld1 = !v1_ff || ld2;
   end

   assign req_ready = ld1;

   always_comb begin
      s1_in.func   = req_func;
      s1_in.eq     = (req_a_real == req_b_real) && (req_a_imag == req_b_imag);
      if (req_func == FUNC_SUB) begin
         s1_in.sum_re = (W+1)'(req_a_real) - (W+1)'(req_b_real);
         s1_in.sum_im = (W+1)'(req_a_imag) - (W+1)'(req_b_imag);
      end else begin
         s1_in.sum_re = (W+1)'(req_a_real) + (W+1)'(req_b_real);
         s1_in.sum_im = (W+1)'(req_a_imag) + (W+1)'(req_b_imag);
      end
      s1_in.p_rr  = req_a_real * req_b_real;
      s1_in.p_ii  = req_a_imag * req_b_imag;
      s1_in.p_ri  = req_a_real * req_b_imag;
      s1_in.p_ir  = req_a_imag * req_b_real;
      s1_in.sq_ar = PW'(req_a_real * req_a_real);
      s1_in.sq_ai = PW'(req_a_imag * req_a_imag);
      s1_in.sq_br = PW'(req_b_real * req_b_real);
      s1_in.sq_bi = PW'(req_b_imag * req_b_imag);
   end

   always_comb begin
      s2_in.func   = s1_ff.func;
      s2_in.eq     = s1_ff.eq;
      s2_in.sum_re = s1_ff.sum_re;
      s2_in.sum_im = s1_ff.sum_im;
      s2_in.mul_re = SW'(s1_ff.p_rr) - SW'(s1_ff.p_ii);
      s2_in.mul_im = SW'(s1_ff.p_ri) + SW'(s1_ff.p_ir);
      s2_in.div_re = SW'(s1_ff.p_rr) + SW'(s1_ff.p_ii);
      s2_in.div_im = SW'(s1_ff.p_ir) - SW'(s1_ff.p_ri);
      s2_in.mod_a  = s1_ff.sq_ar + s1_ff.sq_ai;
      s2_in.mod_b  = s1_ff.sq_br + s1_ff.sq_bi;
   end

   // operation select and divider setup
   always_comb begin
      abs_dre = abs_sw(s2_ff.div_re);
      abs_dim = abs_sw(s2_ff.div_im);
      abs_mre = abs_sw(s2_ff.mul_re);
      abs_mim = abs_sw(s2_ff.mul_im);
      num_re  = NNW'(abs_dre[PW-1:0]) << F;
      num_im  = NNW'(abs_dim[PW-1:0]) << F;
      den_top = CW'(s2_ff.mod_b) << QB;

      dv0_in        = '0;
      dv0_in.den    = s2_ff.mod_b;
      dv0_in.rem_re = num_re;
      dv0_in.rem_im = num_im;
      dv0_in.big_re = CW'(num_re) >= den_top;
      dv0_in.big_im = CW'(num_im) >= den_top;
      case (s2_ff.func)
         FUNC_ADD, FUNC_SUB: begin
            dv0_in.neg_re = s2_ff.sum_re[W];
            dv0_in.neg_im = s2_ff.sum_im[W];
            dv0_in.mag_re = abs_sw(SW'(s2_ff.sum_re));
            dv0_in.mag_im = abs_sw(SW'(s2_ff.sum_im));
         end
         FUNC_MUL: begin
            dv0_in.neg_re = s2_ff.mul_re[SW-1];
            dv0_in.neg_im = s2_ff.mul_im[SW-1];
            dv0_in.mag_re = abs_mre >> F;
            dv0_in.mag_im = abs_mim >> F;
         end
         FUNC_DIV: begin
            if (s2_ff.mod_b == '0) begin
               dv0_in.dz = 1'b1;
            end else begin
               dv0_in.is_div = 1'b1;
               dv0_in.neg_re = s2_ff.div_re[SW-1];
               dv0_in.neg_im = s2_ff.div_im[SW-1];
            end
         end
         FUNC_EQ: dv0_in.cmp = s2_ff.eq;
         FUNC_NE: dv0_in.cmp = !s2_ff.eq;
         FUNC_LT: dv0_in.cmp = s2_ff.mod_a < s2_ff.mod_b;
         FUNC_GT: dv0_in.cmp = s2_ff.mod_a > s2_ff.mod_b;
         FUNC_LE: dv0_in.cmp = s2_ff.mod_a <= s2_ff.mod_b;
         FUNC_GE: dv0_in.cmp = s2_ff.mod_a >= s2_ff.mod_b;
         default: dv0_in.cmp = 1'b0;
      endcase
   end

   // one quotient bit per stage, most significant first
   always_comb begin
      dv_in[0] = dv0_in;
      for (int k = 0; k < QB; k++) begin
         trial[k]     = CW'(dv_ff[k].den) << (QB - 1 - k);
         rx_re[k]     = CW'(dv_ff[k].rem_re);
         rx_im[k]     = CW'(dv_ff[k].rem_im);
         dv_in[k+1]   = dv_ff[k];
         if (rx_re[k] >= trial[k]) begin
            rx_re[k]                        = rx_re[k] - trial[k];
            dv_in[k+1].q_re[QB-1-k]         = 1'b1;
         end
         if (rx_im[k] >= trial[k]) begin
            rx_im[k]                        = rx_im[k] - trial[k];
            dv_in[k+1].q_im[QB-1-k]         = 1'b1;
         end
         dv_in[k+1].rem_re = rx_re[k][NNW-1:0];
         dv_in[k+1].rem_im = rx_im[k][NNW-1:0];
      end
   end

   always_comb begin
      fin_mag_re = dv_ff[QB].mag_re;
      fin_mag_im = dv_ff[QB].mag_im;
      if (dv_ff[QB].is_div) begin
         fin_mag_re = dv_ff[QB].big_re ? '1 : SW'(dv_ff[QB].q_re);
         fin_mag_im = dv_ff[QB].big_im ? '1 : SW'(dv_ff[QB].q_im);
      end
      fin_re = sat(dv_ff[QB].neg_re, fin_mag_re);
      fin_im = sat(dv_ff[QB].neg_im, fin_mag_im);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         dvv_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ld1) begin
            v1_ff <= req_valid;
         end
         if (ld2) begin
            v2_ff <= v1_ff;
         end
         if (ld_dv[0]) begin
            dvv_ff[0] <= v2_ff;
         end
         for (int k = 1; k <= QB; k++) begin
            if (ld_dv[k]) begin
               dvv_ff[k] <= dvv_ff[k-1];
            end
         end
         if (ld_out) begin
            rsp_valid_ff <= dvv_ff[QB];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         s1_ff <= s1_in;
      end
      if (ld2) begin
         s2_ff <= s2_in;
      end
      for (int k = 0; k <= QB; k++) begin
         if (ld_dv[k]) begin
            dv_ff[k] <= dv_in[k];
         end
      end
      if (ld_out) begin
         rsp_res_real_ff <= fin_re[W-1:0];
         rsp_res_imag_ff <= fin_im[W-1:0];
         rsp_cmp_ff      <= dv_ff[QB].cmp;
         rsp_ovf_ff      <= fin_re[W] || fin_im[W];
         rsp_dz_ff       <= dv_ff[QB].dz;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_res_real       = rsp_res_real_ff;
   assign rsp_res_imag       = rsp_res_imag_ff;
   assign rsp_compare_true   = rsp_cmp_ff;
   assign rsp_overflow       = rsp_ovf_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;

`ifndef SYNTHESIS
   a_empty_out_takes_req: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty output stage");

   a_cmp_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_compare_true |-> rsp_res_real == '0 && rsp_res_imag == '0
         && !rsp_overflow && !rsp_divide_by_zero)
      else $error("compare beat carries arithmetic result");

   a_dz_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_res_real == '0
         && rsp_res_imag == '0 && !rsp_overflow)
      else $error("divide by zero beat not cleared");

   a_ovf_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |->
         rsp_res_real == {1'b0, {(W-1){1'b1}}} || rsp_res_real == {1'b1, {(W-1){1'b0}}}
         || rsp_res_imag == {1'b0, {(W-1){1'b1}}}
         || rsp_res_imag == {1'b1, {(W-1){1'b0}}})
      else $error("overflow without saturated part");
`endif

endmodule
